### hw/rtl/alu16_pkg.sv
// ----------------------------------------------------------------------------
// ALU package
// Shared types, operation and condition codes, and flag positions for the
// 16-bit ALU with status flags.
// ----------------------------------------------------------------------------
`default_nettype none

package alu16_pkg;

    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 5;
    localparam int FLAG_W = 4;
    localparam int CC_W   = 4;

    // Flag positions inside the four-bit flag word.
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADDC  = 5'd1,
        OP_SUB   = 5'd2,
        OP_SUBC  = 5'd3,
        OP_CMP   = 5'd4,
        OP_XOR   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_BIT   = 5'd8,
        OP_BIS   = 5'd9,
        OP_BIC   = 5'd10,
        OP_MOV   = 5'd11,
        OP_SWPB  = 5'd12,
        OP_SXT   = 5'd13,
        OP_SRA   = 5'd14,
        OP_RRC   = 5'd15,
        OP_MOVL  = 5'd16,
        OP_MOVLZ = 5'd17,
        OP_MOVLS = 5'd18,
        OP_MOVH  = 5'd19,
        OP_SETCC = 5'd20,
        OP_CLRCC = 5'd21,
        OP_CEX   = 5'd22
    } alu16_op_t;

    typedef enum logic [CC_W-1:0] {
        CC_EQ = 4'd0,
        CC_NE = 4'd1,
        CC_CS = 4'd2,
        CC_CC = 4'd3,
        CC_MI = 4'd4,
        CC_PL = 4'd5,
        CC_VS = 4'd6,
        CC_VC = 4'd7,
        CC_HI = 4'd8,
        CC_LS = 4'd9,
        CC_GE = 4'd10,
        CC_LT = 4'd11,
        CC_GT = 4'd12,
        CC_LE = 4'd13,
        CC_TR = 4'd14,
        CC_FL = 4'd15
    } alu16_cc_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic              byte_mode;
        logic [DATA_W-1:0] source_value;
        logic [DATA_W-1:0] dest_value;
        logic [BYTE_W-1:0] immediate_byte;
        logic [FLAG_W-1:0] flag_mask;
        logic [CC_W-1:0]   condition_code;
    } alu16_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              write_enable;
        logic [FLAG_W-1:0] flags_out;
        logic              condition_true;
    } alu16_rsp_t;

    // Evaluates a conditional-execute test against the current flags.
    function automatic logic cond_eval(alu16_cc_t cc, logic [FLAG_W-1:0] f);
        logic c;
        logic z;
        logic n;
        logic v;
        logic t;
        c = f[FLAG_C];
        z = f[FLAG_Z];
        n = f[FLAG_N];
        v = f[FLAG_V];
        unique case (cc)
            CC_EQ: t = z;
            CC_NE: t = !z;
            CC_CS: t = c;
            CC_CC: t = !c;
            CC_MI: t = n;
            CC_PL: t = !n;
            CC_VS: t = v;
            CC_VC: t = !v;
            CC_HI: t = c && !z;
            CC_LS: t = !c || z;
            CC_GE: t = (n == v);
            CC_LT: t = (n != v);
            CC_GT: t = !z && (n == v);
            CC_LE: t = z || (n != v);
            CC_TR: t = 1'b1;
            CC_FL: t = 1'b0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/alu16_req_if.sv
// ----------------------------------------------------------------------------
// ALU request channel
// Valid/ready channel that carries one decoded operation with its operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface alu16_req_if;
    import alu16_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic              byte_mode;
    logic [DATA_W-1:0] source_value;
    logic [DATA_W-1:0] dest_value;
    logic [BYTE_W-1:0] immediate_byte;
    logic [FLAG_W-1:0] flag_mask;
    logic [CC_W-1:0]   condition_code;

    modport source (
        output valid, opcode, byte_mode, source_value, dest_value,
               immediate_byte, flag_mask, condition_code,
        input  ready
    );

    modport sink (
        input  valid, opcode, byte_mode, source_value, dest_value,
               immediate_byte, flag_mask, condition_code,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/alu16_rsp_if.sv
// ----------------------------------------------------------------------------
// ALU response channel
// Valid/ready channel that carries one result with its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface alu16_rsp_if;
    import alu16_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              write_enable;
    logic [FLAG_W-1:0] flags_out;
    logic              condition_true;

    modport source (
        output valid, result_value, write_enable, flags_out, condition_true,
        input  ready
    );

    modport sink (
        input  valid, result_value, write_enable, flags_out, condition_true,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/alu16_exec.sv
// ----------------------------------------------------------------------------
// ALU execute logic
// Combinational datapath: result value, write enable, next flags and the
// conditional-execute outcome for one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module alu16_exec (
    input  wire alu16_pkg::alu16_req_t           req,
    input  wire logic [alu16_pkg::FLAG_W-1:0]    flags,
    output alu16_pkg::alu16_rsp_t                rsp,
    output logic [alu16_pkg::FLAG_W-1:0]         flags_next
);
    import alu16_pkg::*;

    alu16_op_t         op;
    logic [DATA_W-1:0] wmask;
    logic [DATA_W-1:0] msb;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] dst;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] s;
    logic [DATA_W:0]   sum;
    logic              cin;
    logic              carry;
    logic              in_range;
    logic [DATA_W-1:0] bitm;
    logic              we;
    logic              merge;
    logic              ct;
    logic [FLAG_W-1:0] f;

    assign op    = alu16_op_t'(req.opcode);
    assign src   = req.source_value;
    assign dst   = req.dest_value;
    assign wmask = req.byte_mode ? 16'h00FF : 16'hFFFF;
    assign msb   = req.byte_mode ? 16'h0080 : 16'h8000;
    assign a     = dst & wmask;

    // Shared adder for add, subtract and compare. Subtract adds the one's
    // complement of the source plus a carry-in.
    always_comb
    begin
        unique case (op)
            OP_ADD:        cin = 1'b0;
            OP_SUB,
            OP_CMP:        cin = 1'b1;
            default:       cin = flags[FLAG_C];
        endcase
        s     = ((op == OP_ADD || op == OP_ADDC) ? src : ~src) & wmask;
        sum   = {1'b0, s} + {1'b0, a} + {{DATA_W{1'b0}}, cin};
        carry = req.byte_mode ? sum[BYTE_W] : sum[DATA_W];
    end

    // Bit number selects no bit once it reaches the operand width.
    always_comb
    begin
        in_range = req.byte_mode ? (src[7:0] < 8'd8) : (src < 16'd16);
        bitm     = in_range ? (16'h0001 << src[3:0]) : '0;
    end

    always_comb
    begin
        r     = a;
        res   = dst;
        we    = 1'b0;
        merge = 1'b0;
        ct    = 1'b0;
        f     = flags;
        unique case (op)
            OP_ADD, OP_ADDC, OP_SUB, OP_SUBC, OP_CMP:
            begin
                r         = sum[DATA_W-1:0] & wmask;
                f[FLAG_Z] = (r == '0);
                f[FLAG_N] = |(r & msb);
                f[FLAG_C] = carry;
                f[FLAG_V] = |((s ^ r) & (a ^ r) & msb);
                we        = (op != OP_CMP);
                merge     = (op != OP_CMP);
            end
            OP_XOR, OP_AND, OP_OR, OP_BIS, OP_BIC:
            begin
                unique case (op)
                    OP_XOR:  r = (a ^ src) & wmask;
                    OP_AND:  r = (a & src) & wmask;
                    OP_OR:   r = (a | src) & wmask;
                    OP_BIS:  r = (a | bitm) & wmask;
                    default: r = a & ~bitm & wmask;
                endcase
                f[FLAG_Z] = (r == '0);
                f[FLAG_N] = |(r & msb);
                we        = 1'b1;
                merge     = 1'b1;
            end
            OP_BIT:
            begin
                f[FLAG_Z] = ((a & bitm) == '0);
            end
            OP_MOV:
            begin
                r     = src & wmask;
                we    = 1'b1;
                merge = 1'b1;
            end
            OP_SWPB:
            begin
                res = {dst[7:0], dst[15:8]};
                we  = 1'b1;
            end
            OP_SXT:
            begin
                res = {{BYTE_W{dst[7]}}, dst[7:0]};
                we  = 1'b1;
            end
            OP_SRA:
            begin
                f[FLAG_C] = a[0];
                r         = (a >> 1) | (a & msb);
                we        = 1'b1;
                merge     = 1'b1;
            end
            OP_RRC:
            begin
                f[FLAG_C] = a[0];
                r         = (a >> 1) | (flags[FLAG_C] ? msb : '0);
                we        = 1'b1;
                merge     = 1'b1;
            end
            OP_MOVL:
            begin
                res = {dst[15:8], req.immediate_byte};
                we  = 1'b1;
            end
            OP_MOVLZ:
            begin
                res = {8'h00, req.immediate_byte};
                we  = 1'b1;
            end
            OP_MOVLS:
            begin
                res = {8'hFF, req.immediate_byte};
                we  = 1'b1;
            end
            OP_MOVH:
            begin
                res = {req.immediate_byte, dst[7:0]};
                we  = 1'b1;
            end
            OP_SETCC: f = flags | req.flag_mask;
            OP_CLRCC: f = flags & ~req.flag_mask;
            OP_CEX:   ct = cond_eval(alu16_cc_t'(req.condition_code), flags);
            default:
            begin
                // Unused opcodes leave everything as it was.
                ct = 1'b0;
            end
        endcase
        if (merge)
        begin
            res = (dst & ~wmask) | (r & wmask);
        end
    end

    assign rsp.result_value   = res;
    assign rsp.write_enable   = we;
    assign rsp.flags_out      = f;
    assign rsp.condition_true = ct;
    assign flags_next         = f;

endmodule

`default_nettype wire

### hw/rtl/sixteen_bit_alu_with_status_flags_core.sv
// ----------------------------------------------------------------------------
// 16-bit ALU with status flags
// Execute stage: input register, single-pass ALU logic, result register,
// and the N, Z, C and V status flag register.
// ----------------------------------------------------------------------------
// An accepted request is held in the input register; its result then moves
// into the result register, which drives rsp.valid.
// Throughput: one transaction per cycle while rsp.ready stays high, set by
// the flag loop through the ALU logic; the input register accepts a new
// transaction while a finished result waits in the result register.
// Reset: rst_n clears both valid bits and all four status flags.
`default_nettype none

module sixteen_bit_alu_with_status_flags_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    alu16_req_if.sink    req,
    alu16_rsp_if.source  rsp
);
    import alu16_pkg::*;

    alu16_req_t        req_in;
    alu16_req_t        req_data_reg;
    logic              req_valid_reg;
    logic              req_valid_next;
    alu16_rsp_t        rsp_data_reg;
    alu16_rsp_t        exec_rsp;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [FLAG_W-1:0] flags_reg;
    logic [FLAG_W-1:0] flags_next;
    logic              req_fire;
    logic              advance;

    // Pack the incoming transaction into one struct for the input register.
    assign req_in = '{
        opcode:         req.opcode,
        byte_mode:      req.byte_mode,
        source_value:   req.source_value,
        dest_value:     req.dest_value,
        immediate_byte: req.immediate_byte,
        flag_mask:      req.flag_mask,
        condition_code: req.condition_code
    };

    // The held operation moves into the result register whenever that
    // register is empty or its transaction completes in this cycle. The
    // flags are committed at the same moment, so the next operation always
    // sees the flags left by the one before it.
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    assign req_valid_next = req_fire || (req_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp.ready);

    alu16_exec u_exec (
        .req        (req_data_reg),
        .flags      (flags_reg),
        .rsp        (exec_rsp),
        .flags_next (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_data_reg <= req_in;
        end
        if (advance)
        begin
            rsp_data_reg <= exec_rsp;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.result_value   = rsp_data_reg.result_value;
    assign rsp.write_enable   = rsp_data_reg.write_enable;
    assign rsp.flags_out      = rsp_data_reg.flags_out;
    assign rsp.condition_true = rsp_data_reg.condition_true;

endmodule

`default_nettype wire

### bench/sixteen_bit_alu_with_status_flags_core_test.sv
// ----------------------------------------------------------------------------
// 16-bit ALU execute stage testbench
// Sends decoded operations through the request channel and checks every
// response against a cycle-free model of the ALU and its N, Z, C and V flags.
// A directed set of operations comes first, then a long random mix, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module sixteen_bit_alu_with_status_flags_core_test;
    import alu16_pkg::*;

    // Opcodes past the last defined operation; the block must treat them as
    // no-ops that pass the destination through.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 5'd23;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 5'd31;

    // Idle percentages for the first two traffic phases. The third phase
    // runs with neither side idling.
    localparam int unsigned LIGHT_IDLE_PCT = 25;
    localparam int unsigned HEAVY_IDLE_PCT = 58;

    // Random part of the stimulus and the drain time after the last result.
    localparam int unsigned RANDOM_OPS   = 650;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;

    alu16_req_if req_ch ();
    alu16_rsp_if rsp_ch ();

    sixteen_bit_alu_with_status_flags_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Operations waiting to be driven, and the responses that the model
    // expects back, oldest first.
    alu16_req_t  pending_ops[$];
    alu16_rsp_t  expected_results[$];

    // Flags as the model sees them after every accepted operation.
    logic [FLAG_W-1:0] model_flags;

    int unsigned total_items;
    int unsigned accepted_count;
    int unsigned checked_count;
    int unsigned error_count;

    alu16_req_t staged_op;
    alu16_rsp_t oldest_result;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the ALU
    // ------------------------------------------------------------------------

    // Replaces N and Z with the sign and zero test of a result.
    function automatic logic [FLAG_W-1:0] with_nz(logic [FLAG_W-1:0] f,
                                                  logic [DATA_W-1:0] val,
                                                  logic [DATA_W-1:0] msb);
        logic [FLAG_W-1:0] g;
        g = f;
        g[FLAG_Z] = (val == '0);
        g[FLAG_N] = ((val & msb) != '0);
        return g;
    endfunction

    // Works out the response to one operation and advances model_flags.
    function automatic alu16_rsp_t predict_alu(alu16_req_t op);
        logic [FLAG_W-1:0] f;
        logic [DATA_W-1:0] wmask;
        logic [DATA_W-1:0] msb;
        logic [DATA_W-1:0] width;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] bit_num;
        logic [DATA_W-1:0] bit_sel;
        logic [DATA_W:0]   sum;
        logic              cin;
        logic              is_sub;
        logic              old_c;
        logic              we;
        logic              ct;
        logic              merge;
        logic              c;
        logic              z;
        logic              n;
        logic              v;
        alu16_rsp_t        out;

        f      = model_flags;
        wmask  = op.byte_mode ? 16'h00FF : 16'hFFFF;
        msb    = op.byte_mode ? 16'h0080 : 16'h8000;
        width  = op.byte_mode ? 16'd8 : 16'd16;
        a      = op.dest_value & wmask;
        r      = a;
        res    = op.dest_value;
        we     = 1'b0;
        ct     = 1'b0;
        merge  = 1'b0;

        case (op.opcode)
            OP_ADD, OP_ADDC, OP_SUB, OP_SUBC, OP_CMP:
            begin
                // Subtraction adds the one's complement plus a carry-in.
                is_sub = (op.opcode >= OP_SUB);
                if (op.opcode == OP_ADD)
                    cin = 1'b0;
                else if (op.opcode == OP_SUB || op.opcode == OP_CMP)
                    cin = 1'b1;
                else
                    cin = f[FLAG_C];
                s   = (is_sub ? ~op.source_value : op.source_value) & wmask;
                sum = {1'b0, s} + {1'b0, a} + {{DATA_W{1'b0}}, cin};
                r   = sum[DATA_W-1:0] & wmask;
                f   = with_nz(f, r, msb);
                f[FLAG_C] = (sum > {1'b0, wmask});
                f[FLAG_V] = (((s ^ r) & (a ^ r) & msb) != '0);
                if (op.opcode != OP_CMP)
                begin
                    we    = 1'b1;
                    merge = 1'b1;
                end
            end
            OP_XOR, OP_AND, OP_OR:
            begin
                if (op.opcode == OP_XOR)
                    r = a ^ op.source_value;
                else if (op.opcode == OP_AND)
                    r = a & op.source_value;
                else
                    r = a | op.source_value;
                r     = r & wmask;
                f     = with_nz(f, r, msb);
                we    = 1'b1;
                merge = 1'b1;
            end
            OP_BIT, OP_BIS, OP_BIC:
            begin
                // A bit number past the operand width selects nothing.
                bit_num = op.byte_mode ? {8'h00, op.source_value[7:0]} : op.source_value;
                bit_sel = (bit_num < width) ? (16'h0001 << bit_num) : 16'h0000;
                if (op.opcode == OP_BIT)
                begin
                    f[FLAG_Z] = ((a & bit_sel) == '0);
                end
                else
                begin
                    r     = (op.opcode == OP_BIS) ? (a | bit_sel) : (a & ~bit_sel & wmask);
                    f     = with_nz(f, r, msb);
                    we    = 1'b1;
                    merge = 1'b1;
                end
            end
            OP_MOV:
            begin
                r     = op.source_value & wmask;
                we    = 1'b1;
                merge = 1'b1;
            end
            OP_SWPB:
            begin
                res = {op.dest_value[7:0], op.dest_value[15:8]};
                we  = 1'b1;
            end
            OP_SXT:
            begin
                res = {{8{op.dest_value[7]}}, op.dest_value[7:0]};
                we  = 1'b1;
            end
            OP_SRA:
            begin
                f[FLAG_C] = a[0];
                r         = (a >> 1) | (a & msb);
                we        = 1'b1;
                merge     = 1'b1;
            end
            OP_RRC:
            begin
                old_c     = f[FLAG_C];
                f[FLAG_C] = a[0];
                r         = (a >> 1) | (old_c ? msb : 16'h0000);
                we        = 1'b1;
                merge     = 1'b1;
            end
            OP_MOVL:
            begin
                res = {op.dest_value[15:8], op.immediate_byte};
                we  = 1'b1;
            end
            OP_MOVLZ:
            begin
                res = {8'h00, op.immediate_byte};
                we  = 1'b1;
            end
            OP_MOVLS:
            begin
                res = {8'hFF, op.immediate_byte};
                we  = 1'b1;
            end
            OP_MOVH:
            begin
                res = {op.immediate_byte, op.dest_value[7:0]};
                we  = 1'b1;
            end
            OP_SETCC:
            begin
                f = f | op.flag_mask;
            end
            OP_CLRCC:
            begin
                f = f & ~op.flag_mask;
            end
            OP_CEX:
            begin
                c = f[FLAG_C];
                z = f[FLAG_Z];
                n = f[FLAG_N];
                v = f[FLAG_V];
                case (op.condition_code)
                    CC_EQ: ct = z;
                    CC_NE: ct = !z;
                    CC_CS: ct = c;
                    CC_CC: ct = !c;
                    CC_MI: ct = n;
                    CC_PL: ct = !n;
                    CC_VS: ct = v;
                    CC_VC: ct = !v;
                    CC_HI: ct = c && !z;
                    CC_LS: ct = !c || z;
                    CC_GE: ct = (n == v);
                    CC_LT: ct = (n != v);
                    CC_GT: ct = !z && (n == v);
                    CC_LE: ct = z || (n != v);
                    CC_TR: ct = 1'b1;
                    default: ct = 1'b0;
                endcase
            end
            default:
            begin
            end
        endcase

        // Byte mode keeps the upper byte of the destination.
        if (merge)
            res = (op.dest_value & ~wmask) | (r & wmask);
        if (!we)
            res = op.dest_value;
        model_flags = f;

        out.result_value   = res;
        out.write_enable   = we;
        out.flags_out      = f;
        out.condition_true = ct;
        return out;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic alu16_req_t make_op(logic [OP_W-1:0] code, logic bm,
                                           logic [DATA_W-1:0] src,
                                           logic [DATA_W-1:0] dst,
                                           logic [BYTE_W-1:0] imm,
                                           logic [FLAG_W-1:0] mask,
                                           logic [CC_W-1:0] cc);
        alu16_req_t op;
        op.opcode         = code;
        op.byte_mode      = bm;
        op.source_value   = src;
        op.dest_value     = dst;
        op.immediate_byte = imm;
        op.flag_mask      = mask;
        op.condition_code = cc;
        return op;
    endfunction

    // Operand value that favors the word and byte boundaries where carry,
    // overflow and sign change.
    function automatic logic [DATA_W-1:0] pick_word();
        logic [31:0] rnd;
        logic [DATA_W-1:0] w;
        rnd = $urandom;
        case ($urandom_range(7))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w = 16'h8000;
            3: w = 16'h7FFF;
            4: w = {rnd[15:8], 8'h80};
            5: w = {rnd[15:8], 8'h7F};
            default: w = rnd[15:0];
        endcase
        return w;
    endfunction

    // The first third of the traffic idles the sender lightly and stalls the
    // receiver heavily, the second third swaps the two, the rest runs flat out.
    function automatic int unsigned idle_pct(bit is_sender);
        if (accepted_count < total_items / 3)
            return is_sender ? LIGHT_IDLE_PCT : HEAVY_IDLE_PCT;
        else if (accepted_count < (2 * total_items) / 3)
            return is_sender ? HEAVY_IDLE_PCT : LIGHT_IDLE_PCT;
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // Every accepted transaction is handed to the model right away, so the
    // expected responses line up in the same order as the requests. A new
    // operation is staged only when the bus is free or the current one has
    // just been taken; valid stays high across back-to-back transactions.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                staged_op = {req_ch.opcode, req_ch.byte_mode, req_ch.source_value,
                             req_ch.dest_value, req_ch.immediate_byte,
                             req_ch.flag_mask, req_ch.condition_code};
                expected_results.push_back(predict_alu(staged_op));
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    staged_op = pending_ops.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.opcode         <= staged_op.opcode;
                    req_ch.byte_mode      <= staged_op.byte_mode;
                    req_ch.source_value   <= staged_op.source_value;
                    req_ch.dest_value     <= staged_op.dest_value;
                    req_ch.immediate_byte <= staged_op.immediate_byte;
                    req_ch.flag_mask      <= staged_op.flag_mask;
                    req_ch.condition_code <= staged_op.condition_code;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor
    // ------------------------------------------------------------------------
    // Each accepted response is matched against the oldest expectation. The
    // ready line is redrawn every cycle, so stalls land on every phase of the
    // block's two-stage pipeline.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    error_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    checked_count++;
                    if (rsp_ch.result_value !== oldest_result.result_value)
                    begin
                        $error("result_value: expected %h, actual %h",
                               oldest_result.result_value, rsp_ch.result_value);
                        error_count++;
                    end
                    if (rsp_ch.write_enable !== oldest_result.write_enable)
                    begin
                        $error("write_enable: expected %b, actual %b",
                               oldest_result.write_enable, rsp_ch.write_enable);
                        error_count++;
                    end
                    if (rsp_ch.flags_out !== oldest_result.flags_out)
                    begin
                        $error("flags_out: expected %b, actual %b",
                               oldest_result.flags_out, rsp_ch.flags_out);
                        error_count++;
                    end
                    if (rsp_ch.condition_true !== oldest_result.condition_true)
                    begin
                        $error("condition_true: expected %b, actual %b",
                               oldest_result.condition_true, rsp_ch.condition_true);
                        error_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [31:0]       bits;
        logic [OP_W-1:0]   code;
        logic              bm;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] dst;

        // Every input of the block starts at a known value.
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.opcode         = '0;
        req_ch.byte_mode      = 1'b0;
        req_ch.source_value   = '0;
        req_ch.dest_value     = '0;
        req_ch.immediate_byte = '0;
        req_ch.flag_mask      = '0;
        req_ch.condition_code = '0;
        rsp_ch.ready          = 1'b0;

        model_flags    = '0;
        accepted_count = 0;
        checked_count  = 0;
        error_count    = 0;

        // Directed part. The order matters: several operations rely on the
        // carry or the other flags that the one before leaves behind.
        // Word add that wraps to zero, then a carry-in that overflows.
        pending_ops.push_back(make_op(OP_ADD,  1'b0, 16'h0001, 16'hFFFF, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_ADDC, 1'b0, 16'h0000, 16'h7FFF, 8'h00, 4'h0, CC_EQ));
        // Byte add with signed overflow; the upper byte must survive.
        pending_ops.push_back(make_op(OP_ADD,  1'b1, 16'h0001, 16'hAB7F, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_SUB,  1'b0, 16'h0001, 16'h8000, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_SUBC, 1'b1, 16'h00FF, 16'h1200, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_CMP,  1'b0, 16'h1234, 16'h1234, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_XOR,  1'b0, 16'hFFFF, 16'h5555, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_AND,  1'b1, 16'h00F0, 16'hFF3C, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_OR,   1'b0, 16'h0000, 16'h0000, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_BIT,  1'b0, 16'h000F, 16'h8000, 8'h00, 4'h0, CC_EQ));
        // Bit numbers past the operand width: full word number in word mode,
        // low byte only in byte mode.
        pending_ops.push_back(make_op(OP_BIT,  1'b0, 16'h0010, 16'hFFFF, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_BIT,  1'b1, 16'h0108, 16'hFFFF, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_BIS,  1'b0, 16'hFFFF, 16'h0000, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_BIC,  1'b0, 16'h0000, 16'h0001, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_MOV,  1'b1, 16'hFF80, 16'h3400, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_SWPB, 1'b1, 16'h0000, 16'h12AB, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_SXT,  1'b0, 16'h0000, 16'h0080, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_SRA,  1'b0, 16'h0000, 16'h8001, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_RRC,  1'b1, 16'h0000, 16'h5501, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_MOVL, 1'b0, 16'h0000, 16'h1234, 8'hFF, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_MOVLZ, 1'b1, 16'h0000, 16'hFFFF, 8'h80, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_MOVLS, 1'b0, 16'h0000, 16'h0000, 8'h00, 4'h0, CC_EQ));
        pending_ops.push_back(make_op(OP_MOVH, 1'b0, 16'h0000, 16'hFFFF, 8'h80, 4'h0, CC_EQ));
        // All flags set, then the corrected less-or-equal test; clearing N
        // and C then exercises the corrected lower-or-same test.
        pending_ops.push_back(make_op(OP_SETCC, 1'b0, 16'h0000, 16'h0000, 8'h00, 4'hF, CC_EQ));
        pending_ops.push_back(make_op(OP_CEX,  1'b0, 16'h0000, 16'h0000, 8'h00, 4'h0, CC_LE));
        pending_ops.push_back(make_op(OP_CLRCC, 1'b0, 16'h0000, 16'h0000, 8'h00, 4'h5, CC_EQ));
        pending_ops.push_back(make_op(OP_CEX,  1'b0, 16'h0000, 16'h0000, 8'h00, 4'h0, CC_LS));
        // An unused opcode must leave everything alone.
        pending_ops.push_back(make_op(OP_UNUSED_LAST, 1'b1, 16'hFFFF, 16'hA5A5,
                                      8'hFF, 4'hF, CC_TR));

        // Random part. Most operations are defined ones; a few unused opcodes
        // are mixed in. Bit operations mostly get bit numbers near the
        // operand width so that both sides of the range check are hit.
        repeat (RANDOM_OPS)
        begin
            bits = $urandom_range(OP_CEX, OP_ADD);
            if ($urandom_range(19) == 0)
                bits = $urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST);
            code = bits[OP_W-1:0];
            bits = $urandom;
            bm   = bits[0];
            src  = pick_word();
            dst  = pick_word();
            if ((code == OP_BIT || code == OP_BIS || code == OP_BIC) && $urandom_range(3) != 0)
            begin
                bits = $urandom_range(17);
                if (bm)
                    src = {src[15:8], 4'h0, bits[3:0]};
                else
                    src = bits[15:0];
            end
            bits = $urandom;
            pending_ops.push_back(make_op(code, bm, src, dst, bits[7:0],
                                          bits[11:8], bits[15:12]));
        end
        total_items = pending_ops.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every operation to be taken and answered, then give the
        // pipeline time to show any stray response.
        while (accepted_count < total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d ALU operations (all opcodes, byte and word mode, unused codes).",
                 accepted_count);
        $display("Checked %0d responses field by field; %0d mismatches found.",
                 checked_count, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/alu16_pkg.sv
hw/rtl/alu16_req_if.sv
hw/rtl/alu16_rsp_if.sv
hw/rtl/alu16_exec.sv
hw/rtl/sixteen_bit_alu_with_status_flags_core.sv
bench/sixteen_bit_alu_with_status_flags_core_test.sv
